// ----- sv/sitd_pkg.sv -----
// sitd_pkg: shared types and constants of the signed integer to decimal text unit
// used by the digit cell, the digit row and the top level; depends on nothing
`default_nettype none

package sitd_pkg;

  // magnitude and digit geometry
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam logic [3:0]  DIGIT_CNT  = 4'd10;

  // character codes
  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clear;     // zero the digit
    logic dabble;    // add-3 correction then shift in one bit from below
    logic shift_up;  // take the digit of the lower neighbour
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CONVERT = 4'b0010,
    S_ALIGN   = 4'b0100,
    S_EMIT    = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- sv/sitd_if.sv -----
// sitd_if: valid/ready channel interfaces for the number request and the character request
// holds plain wires only; depends on nothing
`default_nettype none

interface sitd_num_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_char_if;
  logic       valid;
  logic       ready;
  logic [5:0] char_code;
  logic       is_last;
  logic [3:0] total_length;

  modport source (output valid, output char_code, output is_last, output total_length,
                  input ready);
  modport sink   (input valid, input char_code, input is_last, input total_length,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/sitd_cell.sv -----
// sitd_cell: one decimal digit of the conversion row, double-dabble step and shift-up
// depends on sitd_pkg
`default_nettype none

module sitd_cell (
  input  wire logic                clk,
  input  wire sitd_pkg::cell_ctrl_t ctrl,
  input  wire logic                carry_in,
  input  wire logic [3:0]          digit_in,
  output logic                     carry_out,
  output logic [3:0]               digit
);
  import sitd_pkg::*;

  logic [3:0] adj;

  // add 3 to digits of five and above so the shift carries into the next decade
  always_comb begin
    adj       = (digit >= 4'd5) ? (digit + 4'd3) : digit;
    carry_out = adj[3];
  end

  // digit register
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctrl.shift_up) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sitd_digit_row.sv -----
// sitd_digit_row: row of ten digit cells, carry chain upward and digit shift upward
// depends on sitd_pkg and sitd_cell
`default_nettype none

module sitd_digit_row (
  input  wire logic                clk,
  input  wire sitd_pkg::cell_ctrl_t ctrl,
  input  wire logic                serial_in,
  output logic [3:0]               top_digit,
  output logic                     overflow
);
  import sitd_pkg::*;

  logic [NUM_DIGITS:0]   carry;
  logic [3:0]            dig [NUM_DIGITS];

  assign carry[0] = serial_in;

  // cells, least significant at index 0
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [3:0] below;
    if (i == 0) begin : g_bottom
      assign below = 4'd0;
    end else begin : g_inner
      assign below = dig[i-1];
    end
    sitd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (carry[i]),
      .digit_in  (below),
      .carry_out (carry[i+1]),
      .digit     (dig[i])
    );
  end

  assign top_digit = dig[NUM_DIGITS-1];
  assign overflow  = carry[NUM_DIGITS];

endmodule

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii_unit.sv -----
// signed_int_to_decimal_ascii_unit: signed 32-bit integer to decimal ASCII characters
// depends on sitd_pkg, sitd_if, sitd_digit_row
//
//  channel  dir  payload                            request
//  num      in   value[31:0] signed                 one integer
//  chars    out  char_code[5:0] is_last total_length one character, sign then digits
//
// one number at a time: accept, then bit-serial double dabble of the 32-bit magnitude
// through the digit row, then alignment dropping leading zeros, then 1 to 11
// characters at one per cycle while the chars channel is not stalled
// rst is synchronous and clears the sequencer and the output valid
// a stalled chars channel holds the character register and the row until taken
`default_nettype none

module signed_int_to_decimal_ascii_unit (
  input  wire logic clk,
  input  wire logic rst,
  sitd_num_if.sink    num,
  sitd_char_if.source chars
);
  import sitd_pkg::*;

  state_t     state;
  logic [31:0] mag;
  logic        neg;
  logic [4:0]  bit_cnt;
  logic [3:0]  remaining;
  logic [3:0]  total;
  logic        minus_pending;

  logic        o_valid;
  logic [5:0]  o_char;
  logic        o_last;
  logic [3:0]  o_total;

  cell_ctrl_t  ctrl;
  logic [3:0]  top_digit;
  logic        overflow;
  logic        accept;
  logic        out_free;
  logic        align_skip;
  logic        emit_load;

  // handshake and row commands
  always_comb begin
    num.ready     = (state == S_IDLE);
    accept        = num.valid && num.ready;
    out_free      = !o_valid || chars.ready;
    align_skip    = (top_digit == 4'd0) && (remaining > 4'd1);
    emit_load     = (state == S_EMIT) && out_free;
    ctrl.clear    = accept;
    ctrl.dabble   = (state == S_CONVERT);
    ctrl.shift_up = ((state == S_ALIGN) && align_skip) || (emit_load && !minus_pending);
  end

  sitd_digit_row u_row (
    .clk       (clk),
    .ctrl      (ctrl),
    .serial_in (mag[MAG_W-1]),
    .top_digit (top_digit),
    .overflow  (overflow)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (out_free) begin
        o_valid <= (state == S_EMIT);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          if (bit_cnt == 5'(MAG_W - 1)) begin
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (!align_skip) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free && !minus_pending && (remaining == 4'd1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers and character register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          neg     <= num.value[31];
          mag     <= num.value[31] ? (32'd0 - unsigned'(num.value)) : unsigned'(num.value);
          bit_cnt <= 5'd0;
        end
      end
      S_CONVERT: begin
        mag       <= {mag[MAG_W-2:0], 1'b0};
        bit_cnt   <= bit_cnt + 5'd1;
        remaining <= DIGIT_CNT;
      end
      S_ALIGN: begin
        if (align_skip) begin
          remaining <= remaining - 4'd1;
        end else begin
          total         <= remaining + {3'b000, neg};
          minus_pending <= neg;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          o_total <= total;
          if (minus_pending) begin
            o_char        <= ASCII_MINUS;
            o_last        <= 1'b0;
            minus_pending <= 1'b0;
          end else begin
            o_char    <= ASCII_ZERO + {2'b00, top_digit};
            o_last    <= (remaining == 4'd1);
            remaining <= remaining - 4'd1;
          end
        end
      end
      default: begin
        mag <= mag;
      end
    endcase
  end

  assign chars.valid        = o_valid;
  assign chars.char_code    = o_char;
  assign chars.is_last      = o_last;
  assign chars.total_length = o_total;

  // checks
  a_no_row_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONVERT) |-> !overflow)
    else $error("digit row overflow during conversion");

  a_accept_starts_convert: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_CONVERT) && (bit_cnt == 5'd0)))
    else $error("accepted number did not start conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_char == ASCII_MINUS)) |-> !o_last)
    else $error("minus sign marked as last character");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (remaining != 4'd0))
    else $error("emitting with no digits left");

endmodule

`default_nettype wire
